// ===== design/aphc_pkg.sv =====
// ----------------------------------------------------------------------------
// aphc_pkg
// Shared widths, constants, codes and types of the averaged PI heater control
// unit: register indexes, datapath operation codes, controller states.
// ----------------------------------------------------------------------------
package aphc_pkg;

   // sample counter width
   localparam int COUNT_BITS = 16;

   // field widths
   localparam int TEMP_BITS       = 16;
   localparam int SUM_BITS        = 32;
   localparam int TIME_BITS       = 32;
   localparam int CMD_BITS        = 15;
   localparam int PROP_BITS       = 18;
   localparam int IGAIN_BITS      = 20;
   localparam int INTEG_BITS      = 32;
   localparam int ERR_BITS        = TEMP_BITS + 1;
   localparam int MAG_BITS        = TEMP_BITS;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 20;

   // serial divider, one quotient bit per step
   localparam int DIV_STEPS    = SUM_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   // integrator step products
   localparam int SCALE_BITS = 13;
   localparam int GM_BITS    = IGAIN_BITS + MAG_BITS;
   localparam int P_BITS     = GM_BITS + SCALE_BITS;
   localparam int P_LO_BITS  = 25;
   localparam int P_HI_BITS  = P_BITS - P_LO_BITS;
   localparam int LO_BITS    = P_LO_BITS + TIME_BITS;
   localparam int HI_BITS    = P_HI_BITS + TIME_BITS;
   localparam int PROD_BITS  = P_BITS + TIME_BITS;
   localparam int ACC_BITS   = INTEG_BITS + 2;

   // proportional path
   localparam int PM_BITS    = PROP_BITS + 1 + ERR_BITS;
   localparam int TOTAL_BITS = PM_BITS + 9;
   localparam int CMD_SHIFT  = 16;

   // constants
   localparam logic [SCALE_BITS-1:0]        US_SCALE    = 13'd4295;
   localparam logic [CMD_BITS-1:0]          CMD_MAX     = 15'd25600;
   localparam logic signed [ACC_BITS-1:0]   INTEG_LIMIT = 34'sd1174405120;
   localparam logic signed [TEMP_BITS-1:0]  TARGET_OFF  = 16'shFF00;
   localparam logic signed [TEMP_BITS-1:0]  AVG_MAX     = 16'sh7FFF;
   localparam logic signed [TEMP_BITS-1:0]  AVG_MIN     = 16'sh8000;
   localparam logic signed [SUM_BITS:0]     SUM_MAX     = 33'sh0_7FFF_FFFF;
   localparam logic signed [SUM_BITS:0]     SUM_MIN     = 33'sh1_8000_0000;

   // register reset values
   localparam logic signed [TEMP_BITS-1:0] TARGET_RESET = 16'sd11520;
   localparam logic [PROP_BITS-1:0]        PROP_RESET   = 18'd51200;
   localparam logic [IGAIN_BITS-1:0]       IGAIN_RESET  = 20'd19661;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_TARGET = 2'd0,
      REG_PROP   = 2'd1,
      REG_IGAIN  = 2'd2
   } csr_reg_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_SAMPLE    = 4'd1,
      OP_TICK      = 4'd2,
      OP_DIV_STEP  = 4'd3,
      OP_AVG       = 4'd4,
      OP_MUL_GAIN  = 4'd5,
      OP_MUL_SCALE = 4'd6,
      OP_MUL_LO    = 4'd7,
      OP_MUL_HI    = 4'd8,
      OP_INTEG     = 4'd9,
      OP_MUL_PROP  = 4'd10,
      OP_CMD       = 4'd11
   } op_type;

   typedef struct packed {
      op_type op;
      logic   out_load;
      logic   fresh;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic heat_off;
      logic integ_skip;
   } dp_status_type;

   // controller states
   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_DIV   = 11'b000_0000_0010,
      ST_AVG   = 11'b000_0000_0100,
      ST_GAIN  = 11'b000_0000_1000,
      ST_SCALE = 11'b000_0001_0000,
      ST_LO    = 11'b000_0010_0000,
      ST_HI    = 11'b000_0100_0000,
      ST_INTEG = 11'b000_1000_0000,
      ST_PROP  = 11'b001_0000_0000,
      ST_CMD   = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

endpackage

// ===== design/aphc_if.sv =====
// ----------------------------------------------------------------------------
// aphc_if
// Valid/ready channels of the heater control unit: request, response and
// register write.
// ----------------------------------------------------------------------------

// request channel: samples and control ticks
interface aphc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   func;
   logic signed [aphc_pkg::TEMP_BITS-1:0]  temperature;
   logic                                   temp_valid;
   logic [aphc_pkg::TIME_BITS-1:0]         time_us;

   modport source (output valid, output func, output temperature, output temp_valid,
                   output time_us, input ready);
   modport sink   (input valid, input func, input temperature, input temp_valid,
                   input time_us, output ready);
endinterface

// response channel: one per control tick
interface aphc_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [aphc_pkg::CMD_BITS-1:0]          duty;
   logic signed [aphc_pkg::TEMP_BITS-1:0]  avg_temp;
   logic                                   fresh;

   modport source (output valid, output duty, output avg_temp, output fresh,
                   input ready);
   modport sink   (input valid, input duty, input avg_temp, input fresh,
                   output ready);
endinterface

// register write channel
interface aphc_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [aphc_pkg::CSR_INDEX_BITS-1:0]    index;
   logic [aphc_pkg::CSR_DATA_BITS-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/aphc_ctrl.sv =====
// ----------------------------------------------------------------------------
// aphc_ctrl
// Controller of the heater control unit: sequences the divider and the PI
// steps of a control tick and owns the response valid flag.
// ----------------------------------------------------------------------------
module aphc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  aphc_pkg::dp_status_type status,
   output aphc_pkg::dp_cmd_type    cmd
);

   aphc_pkg::state_type                  state_ff, state_in;
   logic [aphc_pkg::DIV_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                                 fresh_ff, fresh_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 req_take;
   logic                                 out_free;

   assign req_ready = (state_ff == aphc_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath command
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = aphc_pkg::OP_NONE;
      cmd.out_load = 1'b0;
      cmd.fresh    = fresh_ff;
      case (state_ff)
         aphc_pkg::ST_IDLE: begin
            if (req_take) begin
               if (!req_func) begin
                  cmd.op = aphc_pkg::OP_SAMPLE;
               end else begin
                  cmd.op   = aphc_pkg::OP_TICK;
                  cnt_in   = '0;
                  fresh_in = !status.count_zero;
                  state_in = status.count_zero ? aphc_pkg::ST_OUT : aphc_pkg::ST_DIV;
               end
            end
         end
         aphc_pkg::ST_DIV: begin
            cmd.op = aphc_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == aphc_pkg::DIV_CNT_BITS'(aphc_pkg::DIV_STEPS - 1)) begin
               state_in = aphc_pkg::ST_AVG;
            end
         end
         aphc_pkg::ST_AVG: begin
            cmd.op = aphc_pkg::OP_AVG;
            if (status.heat_off) begin
               state_in = aphc_pkg::ST_OUT;
            end else if (status.integ_skip) begin
               state_in = aphc_pkg::ST_PROP;
            end else begin
               state_in = aphc_pkg::ST_GAIN;
            end
         end
         aphc_pkg::ST_GAIN: begin
            cmd.op   = aphc_pkg::OP_MUL_GAIN;
            state_in = aphc_pkg::ST_SCALE;
         end
         aphc_pkg::ST_SCALE: begin
            cmd.op   = aphc_pkg::OP_MUL_SCALE;
            state_in = aphc_pkg::ST_LO;
         end
         aphc_pkg::ST_LO: begin
            cmd.op   = aphc_pkg::OP_MUL_LO;
            state_in = aphc_pkg::ST_HI;
         end
         aphc_pkg::ST_HI: begin
            cmd.op   = aphc_pkg::OP_MUL_HI;
            state_in = aphc_pkg::ST_INTEG;
         end
         aphc_pkg::ST_INTEG: begin
            cmd.op   = aphc_pkg::OP_INTEG;
            state_in = aphc_pkg::ST_PROP;
         end
         aphc_pkg::ST_PROP: begin
            cmd.op   = aphc_pkg::OP_MUL_PROP;
            state_in = aphc_pkg::ST_CMD;
         end
         aphc_pkg::ST_CMD: begin
            cmd.op   = aphc_pkg::OP_CMD;
            state_in = aphc_pkg::ST_OUT;
         end
         aphc_pkg::ST_OUT: begin
            // wait for the response register to free up
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = aphc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aphc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aphc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/aphc_dp.sv =====
// ----------------------------------------------------------------------------
// aphc_dp
// Datapath of the heater control unit: configuration registers, sample
// accumulator, serial divider, PI arithmetic and the response register.
// ----------------------------------------------------------------------------
module aphc_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  aphc_pkg::dp_cmd_type                   cmd,
   output aphc_pkg::dp_status_type                status,
   input  logic signed [aphc_pkg::TEMP_BITS-1:0]  req_temperature,
   input  logic                                   req_temp_valid,
   input  logic [aphc_pkg::TIME_BITS-1:0]         req_time_us,
   input  logic                                   csr_write,
   input  logic [aphc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [aphc_pkg::CSR_DATA_BITS-1:0]     csr_data,
   output logic [aphc_pkg::CMD_BITS-1:0]          rsp_duty,
   output logic signed [aphc_pkg::TEMP_BITS-1:0]  rsp_avg_temp,
   output logic                                   rsp_fresh
);

   // configuration
   logic signed [aphc_pkg::TEMP_BITS-1:0]   target_ff;
   logic [aphc_pkg::PROP_BITS-1:0]          prop_ff;
   logic [aphc_pkg::IGAIN_BITS-1:0]         igain_ff;

   // architectural state
   logic signed [aphc_pkg::SUM_BITS-1:0]    sum_ff;
   logic [aphc_pkg::COUNT_BITS-1:0]         count_ff;
   logic signed [aphc_pkg::INTEG_BITS-1:0]  integ_ff;
   logic [aphc_pkg::TIME_BITS-1:0]          prev_time_ff;
   logic [aphc_pkg::CMD_BITS-1:0]           held_cmd_ff;
   logic signed [aphc_pkg::TEMP_BITS-1:0]   held_avg_ff;

   // working registers
   logic [aphc_pkg::TIME_BITS-1:0]          time_ff;
   logic [aphc_pkg::SUM_BITS-1:0]           dq_ff;
   logic [aphc_pkg::COUNT_BITS-1:0]         rem_ff;
   logic [aphc_pkg::COUNT_BITS-1:0]         divisor_ff;
   logic                                    neg_ff;
   logic signed [aphc_pkg::ERR_BITS-1:0]    err_ff;
   logic [aphc_pkg::TIME_BITS-1:0]          dt_ff;
   logic [aphc_pkg::GM_BITS-1:0]            gm_ff;
   logic [aphc_pkg::P_BITS-1:0]             p_ff;
   logic [aphc_pkg::LO_BITS-1:0]            lo_ff;
   logic [aphc_pkg::HI_BITS-1:0]            hi_ff;
   logic signed [aphc_pkg::PM_BITS-1:0]     pm_ff;

   // response register
   logic [aphc_pkg::CMD_BITS-1:0]           out_cmd_ff;
   logic signed [aphc_pkg::TEMP_BITS-1:0]   out_avg_ff;
   logic                                    out_fresh_ff;

   logic signed [aphc_pkg::SUM_BITS:0]      sum_wide;
   logic signed [aphc_pkg::SUM_BITS-1:0]    sum_sat;
   logic [aphc_pkg::SUM_BITS-1:0]           sum_mag;
   logic [aphc_pkg::COUNT_BITS:0]           trial;
   logic                                    trial_ge;
   logic signed [aphc_pkg::TEMP_BITS-1:0]   avg;
   logic signed [aphc_pkg::ERR_BITS-1:0]    err_new;
   logic [aphc_pkg::ERR_BITS-1:0]           err_abs;
   logic [aphc_pkg::PROD_BITS-1:0]          prod;
   logic signed [aphc_pkg::ACC_BITS-1:0]    inc;
   logic signed [aphc_pkg::ACC_BITS-1:0]    acc;
   logic signed [aphc_pkg::INTEG_BITS-1:0]  acc_sat;
   logic signed [aphc_pkg::TOTAL_BITS-1:0]  total;
   logic [aphc_pkg::TOTAL_BITS-aphc_pkg::CMD_SHIFT-1:0] quot;
   logic [aphc_pkg::CMD_BITS-1:0]           cmd_new;

   // status to the controller
   assign status.count_zero = (count_ff == '0);
   assign status.heat_off   = (target_ff == aphc_pkg::TARGET_OFF);
   assign status.integ_skip = (prev_time_ff == '0) || (prev_time_ff == time_ff);

   // saturating sample accumulate
   always_comb begin
      sum_wide = (aphc_pkg::SUM_BITS+1)'(sum_ff) + (aphc_pkg::SUM_BITS+1)'(req_temperature);
      if (sum_wide > aphc_pkg::SUM_MAX) begin
         sum_sat = aphc_pkg::SUM_MAX[aphc_pkg::SUM_BITS-1:0];
      end else if (sum_wide < aphc_pkg::SUM_MIN) begin
         sum_sat = aphc_pkg::SUM_MIN[aphc_pkg::SUM_BITS-1:0];
      end else begin
         sum_sat = sum_wide[aphc_pkg::SUM_BITS-1:0];
      end
      sum_mag = sum_ff[aphc_pkg::SUM_BITS-1] ? (-sum_ff) : sum_ff;
   end

   // divider trial subtract
   assign trial    = {rem_ff, dq_ff[aphc_pkg::SUM_BITS-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});

   // signed average with clamp, and error to target
   always_comb begin
      if (neg_ff) begin
         if (dq_ff >= aphc_pkg::SUM_BITS'(32768)) begin
            avg = aphc_pkg::AVG_MIN;
         end else begin
            avg = -$signed(dq_ff[aphc_pkg::TEMP_BITS-1:0]);
         end
      end else begin
         if (dq_ff > aphc_pkg::SUM_BITS'(32767)) begin
            avg = aphc_pkg::AVG_MAX;
         end else begin
            avg = $signed(dq_ff[aphc_pkg::TEMP_BITS-1:0]);
         end
      end
      err_new = aphc_pkg::ERR_BITS'(target_ff) - aphc_pkg::ERR_BITS'(avg);
      err_abs = err_ff[aphc_pkg::ERR_BITS-1] ? aphc_pkg::ERR_BITS'(-err_ff)
                                             : aphc_pkg::ERR_BITS'(err_ff);
   end

   // integrator step: saturated increment, then clamp to the limit
   always_comb begin
      prod = (aphc_pkg::PROD_BITS'(hi_ff) << aphc_pkg::P_LO_BITS)
           + aphc_pkg::PROD_BITS'(lo_ff);
      if (|prod[aphc_pkg::PROD_BITS-1:64]) begin
         inc = aphc_pkg::ACC_BITS'(34'sh1_0000_0000);
      end else begin
         inc = $signed({2'b00, prod[63:32]});
      end
      if (err_ff[aphc_pkg::ERR_BITS-1]) begin
         acc = aphc_pkg::ACC_BITS'(integ_ff) - inc;
      end else begin
         acc = aphc_pkg::ACC_BITS'(integ_ff) + inc;
      end
      if (acc > aphc_pkg::INTEG_LIMIT) begin
         acc_sat = aphc_pkg::INTEG_BITS'(aphc_pkg::INTEG_LIMIT);
      end else if (acc < -aphc_pkg::INTEG_LIMIT) begin
         acc_sat = aphc_pkg::INTEG_BITS'(-aphc_pkg::INTEG_LIMIT);
      end else begin
         acc_sat = acc[aphc_pkg::INTEG_BITS-1:0];
      end
   end

   // command: p term plus integrator, saturated to 0..100 percent
   always_comb begin
      total = (aphc_pkg::TOTAL_BITS'(pm_ff) <<< 8) + aphc_pkg::TOTAL_BITS'(integ_ff);
      quot  = total[aphc_pkg::TOTAL_BITS-1:aphc_pkg::CMD_SHIFT];
      if (total <= 0) begin
         cmd_new = '0;
      end else if (quot > (aphc_pkg::TOTAL_BITS-aphc_pkg::CMD_SHIFT)'(aphc_pkg::CMD_MAX)) begin
         cmd_new = aphc_pkg::CMD_MAX;
      end else begin
         cmd_new = quot[aphc_pkg::CMD_BITS-1:0];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= aphc_pkg::TARGET_RESET;
         prop_ff   <= aphc_pkg::PROP_RESET;
         igain_ff  <= aphc_pkg::IGAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            aphc_pkg::REG_TARGET: target_ff <= $signed(csr_data[aphc_pkg::TEMP_BITS-1:0]);
            aphc_pkg::REG_PROP:   prop_ff   <= csr_data[aphc_pkg::PROP_BITS-1:0];
            aphc_pkg::REG_IGAIN:  igain_ff  <= csr_data[aphc_pkg::IGAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         integ_ff     <= '0;
         prev_time_ff <= '0;
         held_cmd_ff  <= '0;
         held_avg_ff  <= '0;
      end else begin
         case (cmd.op)
            aphc_pkg::OP_SAMPLE: begin
               if (req_temp_valid && (count_ff != '1)) begin
                  sum_ff   <= sum_sat;
                  count_ff <= count_ff + 1'b1;
               end
            end
            aphc_pkg::OP_AVG: begin
               held_avg_ff <= avg;
               sum_ff      <= '0;
               count_ff    <= '0;
               if (status.heat_off) begin
                  held_cmd_ff <= '0;
               end else begin
                  prev_time_ff <= time_ff;
               end
            end
            aphc_pkg::OP_INTEG: begin
               integ_ff <= acc_sat;
            end
            aphc_pkg::OP_CMD: begin
               held_cmd_ff <= cmd_new;
            end
            default: begin
            end
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         aphc_pkg::OP_TICK: begin
            time_ff    <= req_time_us;
            dq_ff      <= sum_mag;
            neg_ff     <= sum_ff[aphc_pkg::SUM_BITS-1];
            rem_ff     <= '0;
            divisor_ff <= count_ff;
         end
         aphc_pkg::OP_DIV_STEP: begin
            dq_ff <= {dq_ff[aphc_pkg::SUM_BITS-2:0], trial_ge};
            if (trial_ge) begin
               rem_ff <= aphc_pkg::COUNT_BITS'(trial - {1'b0, divisor_ff});
            end else begin
               rem_ff <= trial[aphc_pkg::COUNT_BITS-1:0];
            end
         end
         aphc_pkg::OP_AVG: begin
            err_ff <= err_new;
            dt_ff  <= time_ff - prev_time_ff;
         end
         aphc_pkg::OP_MUL_GAIN: begin
            gm_ff <= aphc_pkg::GM_BITS'(igain_ff)
                   * aphc_pkg::GM_BITS'(err_abs[aphc_pkg::MAG_BITS-1:0]);
         end
         aphc_pkg::OP_MUL_SCALE: begin
            p_ff <= aphc_pkg::P_BITS'(gm_ff) * aphc_pkg::P_BITS'(aphc_pkg::US_SCALE);
         end
         aphc_pkg::OP_MUL_LO: begin
            lo_ff <= aphc_pkg::LO_BITS'(p_ff[aphc_pkg::P_LO_BITS-1:0])
                   * aphc_pkg::LO_BITS'(dt_ff);
         end
         aphc_pkg::OP_MUL_HI: begin
            hi_ff <= aphc_pkg::HI_BITS'(p_ff[aphc_pkg::P_BITS-1:aphc_pkg::P_LO_BITS])
                   * aphc_pkg::HI_BITS'(dt_ff);
         end
         aphc_pkg::OP_MUL_PROP: begin
            pm_ff <= $signed({1'b0, prop_ff}) * err_ff;
         end
         default: begin
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_cmd_ff   <= held_cmd_ff;
         out_avg_ff   <= held_avg_ff;
         out_fresh_ff <= cmd.fresh;
      end
   end

   assign rsp_duty     = out_cmd_ff;
   assign rsp_avg_temp = out_avg_ff;
   assign rsp_fresh    = out_fresh_ff;

endmodule

// ===== design/averaged_pi_heater_control_unit.sv =====
// ----------------------------------------------------------------------------
// averaged_pi_heater_control_unit
// Averaged PI heater controller with integrator clamp.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries temperature samples (func 0) and control ticks (func 1).
//  A sample with temp_valid set adds into the running sum and count while the count is below its maximum.
//  Every tick gives one response on rsp_chan: heater command, held average
//  and a fresh flag; samples give none.
//  A tick without samples goes straight to output. A tick with samples runs
//  a serial divider (one quotient bit per cycle), then the PI steps on a
//  shared sequence of multiplies (average, gain, scale, low, high, integ,
//  prop, cmd); heating off goes from average straight to output, and a
//  skipped integrator step from average to prop. One tick is processed at a
//  time; the next request is taken in the cycle after the response is loaded.
//  The response sits in an output register; samples are still accepted while
//  it waits, and a finishing tick waits, holding off requests, until the
//  receiver takes it.
//  csr_chan writes setpoint (0), proportional gain (1), integral gain (2).
//  It is always ready; the user writes it only while idle, which is not enforced.
//  Synchronous reset restores the register defaults, clears sum, count,
//  integrator, timestamp and held outputs, and drops any pending response.
// ----------------------------------------------------------------------------
module averaged_pi_heater_control_unit (
   input  logic         clock,
   input  logic         reset,
   aphc_req_if.sink     req_chan,
   aphc_rsp_if.source   rsp_chan,
   aphc_csr_if.sink     csr_chan
);

   aphc_pkg::dp_cmd_type    cmd;
   aphc_pkg::dp_status_type status;
   logic                    csr_write;

   // register writes are always accepted
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   // sequencer
   aphc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   aphc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_temperature (req_chan.temperature),
      .req_temp_valid  (req_chan.temp_valid),
      .req_time_us     (req_chan.time_us),
      .csr_write       (csr_write),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_duty        (rsp_chan.duty),
      .rsp_avg_temp    (rsp_chan.avg_temp),
      .rsp_fresh       (rsp_chan.fresh)
   );

endmodule

// ===== design/aphc_checker.sv =====
// ----------------------------------------------------------------------------
// aphc_checker
// Port-level checks of the heater control unit, bound to the top level.
// ----------------------------------------------------------------------------
module aphc_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   req_func,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [aphc_pkg::CMD_BITS-1:0]          rsp_duty,
   input logic signed [aphc_pkg::TEMP_BITS-1:0]  rsp_avg_temp,
   input logic                                   rsp_fresh
);

   // reset drops any pending response
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_duty) && $stable(rsp_avg_temp) && $stable(rsp_fresh))
      else $error("response payload changed while stalled");

   // command never leaves 0..100 percent
   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty <= aphc_pkg::CMD_MAX)
      else $error("heater command out of range");

   // a sample request never produces a response
   a_sample_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_func && !rsp_valid |=> !rsp_valid)
      else $error("response after a sample request");

endmodule

bind averaged_pi_heater_control_unit aphc_checker u_aphc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_func     (req_chan.func),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_duty     (rsp_chan.duty),
   .rsp_avg_temp (rsp_chan.avg_temp),
   .rsp_fresh    (rsp_chan.fresh)
);
